// ===== src/lsm_pkg.sv =====
// Shared constants and types for the line substring match block.
`timescale 1ns / 1ps
`default_nettype none

package lsm_pkg;

   localparam int MAX_QUERY_BYTES = 32;
   localparam int ROW_BITS        = 16;
   localparam int COLUMN_BITS     = 16;
   localparam int COUNT_BITS      = 20;
   localparam int START_BITS      = COLUMN_BITS + 1;
   localparam int LEN_BITS        = 6;
   localparam int QUERY_WORDS     = 4;
   localparam int WORD_BITS       = 64;
   localparam int WORD_BYTES      = WORD_BITS / 8;
   localparam int STORED_BYTES    = QUERY_WORDS * WORD_BYTES;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int MODE_BITS       = 2;

   typedef logic [MODE_BITS-1:0]      mode_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam mode_type MODE_TEXT       = 2'd0;
   localparam mode_type MODE_LINE_END   = 2'd1;
   localparam mode_type MODE_BUFFER_END = 2'd2;

   localparam csr_index_type CSR_LENGTH = 3'd0;
   localparam csr_index_type CSR_WORD_0 = 3'd1;
   localparam csr_index_type CSR_WORD_3 = 3'd4;

   // Query as seen by the window: lane i holds the byte that must sit i places
   // behind the newest byte, and lane_en marks the lanes the query covers.
   typedef struct packed {
      logic [MAX_QUERY_BYTES-1:0][7:0] aligned;
      logic [MAX_QUERY_BYTES-1:0]      lane_en;
      logic                            len_ok;
      logic [LEN_BITS-1:0]             len;
   } query_type;

endpackage

`default_nettype wire

// ===== src/lsm_csr.sv =====
// Query registers and the alignment of the query onto the window lanes.
`timescale 1ns / 1ps
`default_nettype none

module lsm_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [lsm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [lsm_pkg::WORD_BITS-1:0]  csr_data,
   output lsm_pkg::query_type                  query
);

   logic [lsm_pkg::LEN_BITS-1:0]                              length_ff;
   logic [lsm_pkg::QUERY_WORDS-1:0][lsm_pkg::WORD_BITS-1:0]   words_ff;
   logic [lsm_pkg::STORED_BYTES-1:0][7:0]                     query_bytes;

   assign csr_ready   = 1'b1;
   assign query_bytes = words_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         words_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index) inside
            lsm_pkg::CSR_LENGTH: begin
               length_ff <= csr_data[lsm_pkg::LEN_BITS-1:0];
            end
            [lsm_pkg::CSR_WORD_0:lsm_pkg::CSR_WORD_3]: begin
               words_ff[2'(csr_index - lsm_pkg::CSR_WORD_0)] <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Reverse the query so that its last byte meets the newest window byte.
   always_comb begin
      logic [lsm_pkg::LEN_BITS-1:0] src;
      query.len    = length_ff;
      query.len_ok = (length_ff != '0) &&
                     (length_ff <= lsm_pkg::LEN_BITS'(lsm_pkg::MAX_QUERY_BYTES));
      for (int i = 0; i < lsm_pkg::MAX_QUERY_BYTES; i++) begin
         src = lsm_pkg::LEN_BITS'(length_ff - lsm_pkg::LEN_BITS'(i) - 1'b1);
         query.lane_en[i] = lsm_pkg::LEN_BITS'(i) < length_ff;
         query.aligned[i] = query_bytes[src[$clog2(lsm_pkg::STORED_BYTES)-1:0]];
      end
   end

endmodule

`default_nettype wire

// ===== src/lsm_window.sv =====
// Window of the most recent text bytes and its parallel compare against the query.
`timescale 1ns / 1ps
`default_nettype none

module lsm_window (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               shift,
   input  wire logic [7:0]         text_byte,
   input  wire lsm_pkg::query_type query,
   output logic                    hit
);

   logic [lsm_pkg::MAX_QUERY_BYTES-1:0][7:0] recent_ff;
   logic [lsm_pkg::MAX_QUERY_BYTES-1:0][7:0] recent_in;
   logic [lsm_pkg::MAX_QUERY_BYTES-1:0]      lane_ok;

   // Newest byte at lane 0; the window as it stands once this byte is in.
   always_comb begin
      recent_in[0] = text_byte;
      for (int i = 1; i < lsm_pkg::MAX_QUERY_BYTES; i++) begin
         recent_in[i] = recent_ff[i-1];
      end
      for (int i = 0; i < lsm_pkg::MAX_QUERY_BYTES; i++) begin
         lane_ok[i] = !query.lane_en[i] || (recent_in[i] == query.aligned[i]);
      end
   end

   assign hit = &lane_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff <= '0;
      end else if (shift) begin
         recent_ff <= recent_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/line_substring_match_all_core.sv =====
// Top level of the streaming all-matches substring search.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------
//  req     | in        | req_valid / req_stall   | req_mode, req_text_byte
//  rsp     | out       | rsp_valid / rsp_stall   | rsp_match_row, rsp_match_column,
//          |           |                         | rsp_buffer_done, rsp_match_total
//  csr     | in        | csr_valid / csr_ready   | csr_index, csr_data
//
// One word per cycle sustained while rsp does not stall: a word is held in the input register,
// then the window compare, counters and result register update as it leaves that register.
// A word leaves the input register whenever the result register is empty or
// being taken, so a result passes the input register and then the result register.
// Reset (synchronous) clears the window, counters, query and both valid flags.
// A stall on rsp holds the result and, once the input register is full, stalls req.
`timescale 1ns / 1ps
`default_nettype none

module line_substring_match_all_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [1:0]                          req_mode,
   input  wire logic [7:0]                          req_text_byte,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [lsm_pkg::ROW_BITS-1:0]             rsp_match_row,
   output logic [lsm_pkg::COLUMN_BITS-1:0]          rsp_match_column,
   output logic                                     rsp_buffer_done,
   output logic [lsm_pkg::COUNT_BITS-1:0]           rsp_match_total,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lsm_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [lsm_pkg::WORD_BITS-1:0]       csr_data
);

   lsm_pkg::query_type query;

   // Input register
   logic                     in_valid_ff;
   lsm_pkg::mode_type        in_mode_ff;
   logic [7:0]               in_byte_ff;

   // Line and buffer counters
   logic [lsm_pkg::ROW_BITS-1:0]    row_ff,    row_in;
   logic [lsm_pkg::COLUMN_BITS-1:0] col_ff,    col_in;
   logic [lsm_pkg::START_BITS-1:0]  nas_ff,    nas_in;
   logic [lsm_pkg::COUNT_BITS-1:0]  found_ff,  found_in;

   // Result register
   logic                            out_valid_ff;
   logic [lsm_pkg::ROW_BITS-1:0]    out_row_ff,   out_row_in;
   logic [lsm_pkg::COLUMN_BITS-1:0] out_col_ff,   out_col_in;
   logic                            out_done_ff,  out_done_in;
   logic [lsm_pkg::COUNT_BITS-1:0]  out_total_ff, out_total_in;
   logic                            out_load;

   logic                            out_free;
   logic                            consume;
   logic                            shift;
   logic                            window_hit;
   logic [lsm_pkg::COLUMN_BITS-1:0] col_step;
   logic [lsm_pkg::START_BITS-1:0]  start;
   logic                            match;

   lsm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .query     (query)
   );

   lsm_window u_window (
      .clock     (clock),
      .reset     (reset),
      .shift     (shift),
      .text_byte (in_byte_ff),
      .query     (query),
      .hit       (window_hit)
   );

   // Advance the input word whenever the result register can take a result.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign consume   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign shift     = consume && (in_mode_ff == lsm_pkg::MODE_TEXT);

   // Column after this byte, held at all ones; start column of a candidate match.
   assign col_step = (col_ff != '1) ? col_ff + 1'b1 : col_ff;
   assign start    = lsm_pkg::START_BITS'({1'b0, col_step} -
                                          lsm_pkg::START_BITS'(query.len));
   assign match    = query.len_ok && window_hit &&
                     ({1'b0, col_step} >= lsm_pkg::START_BITS'(query.len)) &&
                     (start >= nas_ff);

   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      nas_in       = nas_ff;
      found_in     = found_ff;
      out_load     = 1'b0;
      out_row_in   = '0;
      out_col_in   = '0;
      out_done_in  = 1'b0;
      out_total_in = '0;
      unique case (in_mode_ff)
         lsm_pkg::MODE_TEXT: begin
            col_in = col_step;
            if (match) begin
               nas_in     = {1'b0, col_step};
               found_in   = (found_ff != '1) ? found_ff + 1'b1 : found_ff;
               out_load   = 1'b1;
               out_row_in = row_ff;
               out_col_in = start[lsm_pkg::COLUMN_BITS-1:0];
            end
         end
         lsm_pkg::MODE_LINE_END: begin
            row_in = (row_ff != '1) ? row_ff + 1'b1 : row_ff;
            col_in = '0;
            nas_in = '0;
         end
         lsm_pkg::MODE_BUFFER_END: begin
            out_load     = 1'b1;
            out_done_in  = 1'b1;
            out_total_in = found_ff;
            row_in       = '0;
            col_in       = '0;
            nas_in       = '0;
            found_in     = '0;
         end
         default: begin
            // drop the unused mode code
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         nas_ff       <= '0;
         found_ff     <= '0;
      end else begin
         // hold the input word while stalled, refill it on acceptance
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (consume) begin
            in_valid_ff <= 1'b0;
         end
         if (consume) begin
            row_ff   <= row_in;
            col_ff   <= col_in;
            nas_ff   <= nas_in;
            found_ff <= found_in;
         end
         if (out_free) begin
            out_valid_ff <= consume && out_load;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_mode_ff <= req_mode;
         in_byte_ff <= req_text_byte;
      end
      if (consume && out_load) begin
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         out_done_ff  <= out_done_in;
         out_total_ff <= out_total_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_match_row    = out_row_ff;
   assign rsp_match_column = out_col_ff;
   assign rsp_buffer_done  = out_done_ff;
   assign rsp_match_total  = out_total_ff;

   // The next permitted start never passes the current column.
   assert property (@(posedge clock) disable iff (reset)
      nas_ff <= {1'b0, col_ff})
      else $error("next allowed start beyond current column");

   // A buffer end leaves all counters cleared.
   assert property (@(posedge clock) disable iff (reset)
      consume && (in_mode_ff == lsm_pkg::MODE_BUFFER_END) |=>
         (row_ff == '0) && (col_ff == '0) && (found_ff == '0) && (nas_ff == '0))
      else $error("counters not cleared after buffer end");

   // A buffer-end result carries no position; a match result carries no total.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_buffer_done |-> (rsp_match_row == '0) && (rsp_match_column == '0))
      else $error("buffer-end result with a position");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_buffer_done |-> (rsp_match_total == '0))
      else $error("match result with a total");

   // A match moves the next allowed start up to the column just past it.
   assert property (@(posedge clock) disable iff (reset)
      consume && (in_mode_ff == lsm_pkg::MODE_TEXT) && match |=>
         (nas_ff == {1'b0, col_ff}) && rsp_valid)
      else $error("match did not advance next allowed start");

endmodule

`default_nettype wire

// ===== sim/line_substring_match_all_core_tb.sv =====
// Self-checking testbench for the streaming all-matches substring search core.
`timescale 1ns / 1ps

module line_substring_match_all_core_tb;

   // Mode 3 carries no meaning; the core must drop it.
   localparam lsm_pkg::mode_type      MODE_UNUSED    = 2'd3;
   // First register index past the query words; writes there must change nothing.
   localparam lsm_pkg::csr_index_type CSR_SPARE      = lsm_pkg::CSR_WORD_3 + 3'd1;
   localparam int                     WATCHDOG_LIMIT = 4000;
   localparam int                     PRINT_LIMIT    = 100;
   localparam logic [7:0]             CHAR_A         = 8'h61;

   typedef struct packed {
      logic [lsm_pkg::ROW_BITS-1:0]    row;
      logic [lsm_pkg::COLUMN_BITS-1:0] column;
      logic                            done;
      logic [lsm_pkg::COUNT_BITS-1:0]  total;
   } match_report_type;

   typedef logic [lsm_pkg::QUERY_WORDS-1:0][lsm_pkg::WORD_BITS-1:0] query_words_type;

   logic                            clock         = 1'b0;
   logic                            reset         = 1'b1;
   logic                            req_valid     = 1'b0;
   logic                            req_stall;
   lsm_pkg::mode_type               req_mode      = lsm_pkg::MODE_TEXT;
   logic [7:0]                      req_text_byte = 8'h00;
   logic                            rsp_valid;
   logic                            rsp_stall     = 1'b0;
   logic [lsm_pkg::ROW_BITS-1:0]    rsp_match_row;
   logic [lsm_pkg::COLUMN_BITS-1:0] rsp_match_column;
   logic                            rsp_buffer_done;
   logic [lsm_pkg::COUNT_BITS-1:0]  rsp_match_total;
   logic                            csr_valid     = 1'b0;
   logic                            csr_ready;
   lsm_pkg::csr_index_type          csr_index     = lsm_pkg::CSR_LENGTH;
   logic [lsm_pkg::WORD_BITS-1:0]   csr_data      = '0;

   // Shadow of the core: the query registers and the scan state, all at reset values.
   logic [lsm_pkg::LEN_BITS-1:0]    shadow_length = '0;
   query_words_type                 query_words   = '0;
   logic [7:0]                      window_bytes [lsm_pkg::MAX_QUERY_BYTES];
   logic [lsm_pkg::COLUMN_BITS-1:0] line_column   = '0;
   logic [lsm_pkg::ROW_BITS-1:0]    line_row      = '0;
   logic [lsm_pkg::START_BITS-1:0]  min_start     = '0;
   logic [lsm_pkg::COUNT_BITS-1:0]  found_total   = '0;

   match_report_type       pending_reports [$];
   match_report_type       observed;
   int unsigned            mismatch_count     = 0;
   int unsigned            quiet_cycles       = 0;
   int unsigned            sender_idle_pct    = 0;
   int unsigned            receiver_stall_pct = 0;

   line_substring_match_all_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_match_row    (rsp_match_row),
      .rsp_match_column (rsp_match_column),
      .rsp_buffer_done  (rsp_buffer_done),
      .rsp_match_total  (rsp_match_total),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   initial begin
      for (int i = 0; i < lsm_pkg::MAX_QUERY_BYTES; i++) window_bytes[i] = 8'h00;
   end

   // Advance the shadow state by one accepted word. Return 1 and fill the report
   // when the word produces a result.
   function automatic bit scan_word(input lsm_pkg::mode_type mode, input logic [7:0] text,
                                    output match_report_type report);
      int unsigned len;
      int unsigned start_column;
      bit          hit;
      report = '0;
      hit    = 1'b0;
      case (mode)
         lsm_pkg::MODE_TEXT: begin
            for (int i = lsm_pkg::MAX_QUERY_BYTES - 1; i > 0; i--)
               window_bytes[i] = window_bytes[i-1];
            window_bytes[0] = text;
            // The column holds at all-ones, but the window keeps shifting.
            if (line_column != '1) line_column = line_column + 1'b1;
            len = shadow_length;
            if (len >= 1 && len <= lsm_pkg::MAX_QUERY_BYTES && line_column >= len) begin
               start_column = line_column - len;
               if (start_column >= min_start) begin
                  hit = 1'b1;
                  // Query byte j must sit len-1-j places behind the newest byte.
                  for (int j = 0; j < len; j++) begin
                     if (window_bytes[len-1-j] !==
                         query_words[j / lsm_pkg::WORD_BYTES]
                                    [8 * (j % lsm_pkg::WORD_BYTES) +: 8])
                        hit = 1'b0;
                  end
               end
               if (hit) begin
                  // No overlap: the next match may not start before this one ends.
                  min_start = lsm_pkg::START_BITS'(line_column);
                  if (found_total != '1) found_total = found_total + 1'b1;
                  report.row    = line_row;
                  report.column = lsm_pkg::COLUMN_BITS'(start_column);
               end
            end
         end
         lsm_pkg::MODE_LINE_END: begin
            if (line_row != '1) line_row = line_row + 1'b1;
            line_column = '0;
            min_start   = '0;
         end
         lsm_pkg::MODE_BUFFER_END: begin
            hit          = 1'b1;
            report.done  = 1'b1;
            report.total = found_total;
            line_row     = '0;
            line_column  = '0;
            min_start    = '0;
            found_total  = '0;
         end
         default: ;
      endcase
      return hit;
   endfunction

   // Present one word on req, with random idle cycles ahead of it, and return at
   // the falling edge after it is taken. Valid is left as it is for the next word.
   task automatic send_word(input lsm_pkg::mode_type mode, input logic [7:0] text);
      match_report_type report;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid     <= 1'b0;
         req_mode      <= lsm_pkg::mode_type'($urandom);
         req_text_byte <= 8'($urandom);
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_text_byte <= text;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (scan_word(mode, text, report)) pending_reports.push_back(report);
      @(negedge clock);
   endtask

   // Drop valid, wait for every pending result, then allow for words that give
   // none but may still be inside the two-stage pipeline.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // One register write; csr_valid stays high for a following write.
   task automatic csr_put(input lsm_pkg::csr_index_type index,
                          input logic [lsm_pkg::WORD_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == lsm_pkg::CSR_LENGTH)
         shadow_length = data[lsm_pkg::LEN_BITS-1:0];
      else if (index >= lsm_pkg::CSR_WORD_0 && index <= lsm_pkg::CSR_WORD_3)
         query_words[2'(index - lsm_pkg::CSR_WORD_0)] = data;
      @(negedge clock);
   endtask

   task automatic load_query(input logic [lsm_pkg::WORD_BITS-1:0] len_data,
                             input query_words_type words);
      settle();
      csr_put(lsm_pkg::CSR_LENGTH, len_data);
      for (int k = 0; k < lsm_pkg::QUERY_WORDS; k++)
         csr_put(lsm_pkg::csr_index_type'(lsm_pkg::CSR_WORD_0 + k), words[k]);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
      sender_idle_pct    = sender_pct;
      receiver_stall_pct = receiver_pct;
   endtask

   // Query length zero out of reset: no matches, a zero total, and writes to
   // indexes past the query words leave everything alone.
   task automatic test_reset_defaults();
      set_idling(0, 0);
      send_word(lsm_pkg::MODE_TEXT, 8'h00);
      send_word(lsm_pkg::MODE_TEXT, CHAR_A);
      send_word(lsm_pkg::MODE_LINE_END, 8'hFF);
      send_word(lsm_pkg::MODE_BUFFER_END, 8'h00);
      settle();
      csr_put(CSR_SPARE, '1);
      csr_put(CSR_SPARE + 3'd2, '1);
      csr_valid <= 1'b0;
   endtask

   // Two-byte query: non-overlap, no match across a line end, mode 3 dropped,
   // then a one-byte query at the byte extremes.
   task automatic test_directed_matches();
      query_words_type words;
      set_idling(14, 14);
      words    = '1;
      words[0] = 64'h0123_4567_89AB_6161;
      load_query(64'd2, words);
      repeat (4) send_word(lsm_pkg::MODE_TEXT, CHAR_A);
      send_word(lsm_pkg::MODE_LINE_END, CHAR_A);
      send_word(lsm_pkg::MODE_TEXT, CHAR_A);
      send_word(lsm_pkg::MODE_LINE_END, 8'h00);
      send_word(lsm_pkg::MODE_TEXT, CHAR_A);
      send_word(MODE_UNUSED, CHAR_A);
      send_word(lsm_pkg::MODE_TEXT, CHAR_A);
      send_word(lsm_pkg::MODE_BUFFER_END, 8'hFF);
      words    = '0;
      words[0] = 64'hFF;
      load_query(64'd1, words);
      send_word(lsm_pkg::MODE_TEXT, 8'hFF);
      send_word(lsm_pkg::MODE_TEXT, 8'h00);
      send_word(lsm_pkg::MODE_TEXT, 8'hFF);
      send_word(lsm_pkg::MODE_BUFFER_END, 8'h00);
   endtask

   // Full 32-byte query, then lengths past the limit with junk in the upper
   // bits of the length register.
   task automatic test_query_extremes();
      logic [lsm_pkg::WORD_BITS-1:0] len_data;
      set_idling(14, 14);
      load_query(lsm_pkg::WORD_BITS'(lsm_pkg::MAX_QUERY_BYTES), '1);
      repeat (lsm_pkg::MAX_QUERY_BYTES + 3) send_word(lsm_pkg::MODE_TEXT, 8'hFF);
      send_word(lsm_pkg::MODE_LINE_END, 8'h00);
      len_data                          = '1;
      len_data[lsm_pkg::LEN_BITS-1:0]   = lsm_pkg::LEN_BITS'(lsm_pkg::MAX_QUERY_BYTES + 1);
      load_query(len_data, '0);
      repeat (lsm_pkg::MAX_QUERY_BYTES + 8) send_word(lsm_pkg::MODE_TEXT, 8'h00);
      len_data[lsm_pkg::LEN_BITS-1:0]   = '1;
      load_query(len_data, '1);
      repeat (10) send_word(lsm_pkg::MODE_TEXT, 8'hFF);
      send_word(lsm_pkg::MODE_BUFFER_END, 8'h00);
   endtask

   // Buffers of short lines over a two-letter alphabet with whole copies of the
   // query dropped in, plus stray bytes, mode 3 noise and missing line ends.
   task automatic test_random_buffers(input int unsigned sender_pct,
                                      input int unsigned receiver_pct,
                                      input int unsigned budget);
      int unsigned                   sent;
      int unsigned                   len;
      int unsigned                   pick;
      int unsigned                   line_len;
      logic [7:0]                    letters [2];
      logic [7:0]                    pattern [lsm_pkg::MAX_QUERY_BYTES];
      query_words_type               words;
      logic [lsm_pkg::WORD_BITS-1:0] len_data;
      set_idling(sender_pct, receiver_pct);
      sent = 0;
      while (sent < budget) begin
         letters[0] = 8'($urandom);
         letters[1] = 8'($urandom);
         pick = $urandom_range(0, 19);
         if (pick == 0)      len = 0;
         else if (pick == 1) len = $urandom_range(lsm_pkg::MAX_QUERY_BYTES + 1, 63);
         else if (pick <= 3) len = $urandom_range(17, lsm_pkg::MAX_QUERY_BYTES);
         else                len = $urandom_range(1, 4);
         for (int k = 0; k < lsm_pkg::QUERY_WORDS; k++) words[k] = {$urandom, $urandom};
         for (int j = 0; j < lsm_pkg::MAX_QUERY_BYTES; j++) begin
            pattern[j] = letters[$urandom_range(0, 1)];
            if (j < len)
               words[j / lsm_pkg::WORD_BYTES][8 * (j % lsm_pkg::WORD_BYTES) +: 8] = pattern[j];
         end
         len_data = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
         len_data[lsm_pkg::LEN_BITS-1:0] = lsm_pkg::LEN_BITS'(len);
         load_query(len_data, words);
         repeat ($urandom_range(2, 6)) begin
            line_len = $urandom_range(0, (len > 4) ? 6 : 24);
            for (int c = 0; c < line_len; c++) begin
               pick = $urandom_range(0, 99);
               if (pick < 20 && len >= 1 && len <= lsm_pkg::MAX_QUERY_BYTES) begin
                  for (int j = 0; j < len; j++) send_word(lsm_pkg::MODE_TEXT, pattern[j]);
                  sent += len;
               end else if (pick < 23) begin
                  send_word(MODE_UNUSED, 8'($urandom));
               end else begin
                  send_word(lsm_pkg::MODE_TEXT,
                            (pick < 35) ? 8'($urandom) : letters[$urandom_range(0, 1)]);
                  sent++;
               end
            end
            if ($urandom_range(0, 9) != 0) begin
               send_word(lsm_pkg::MODE_LINE_END, 8'($urandom));
               sent++;
            end
         end
         send_word(lsm_pkg::MODE_BUFFER_END, 8'($urandom));
         sent++;
      end
   endtask

   // Receiver: stall at random; the rate is set per phase.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   // Take each result word and compare it with the oldest pending one.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         observed = '{row: rsp_match_row, column: rsp_match_column,
                      done: rsp_buffer_done, total: rsp_match_total};
         if (pending_reports.size() == 0) begin
            if (mismatch_count < PRINT_LIMIT)
               $display("%0t rsp word with nothing pending: row %0d column %0d done %0d total %0d",
                        $time, observed.row, observed.column, observed.done, observed.total);
            mismatch_count++;
         end else begin
            if (observed !== pending_reports[0]) begin
               if (mismatch_count < PRINT_LIMIT)
                  $display({"%0t rsp wrong: expected row %0d column %0d done %0d total %0d,",
                            " actual row %0d column %0d done %0d total %0d"}, $time,
                           pending_reports[0].row, pending_reports[0].column,
                           pending_reports[0].done, pending_reports[0].total,
                           observed.row, observed.column, observed.done, observed.total);
               mismatch_count++;
            end
            void'(pending_reports.pop_front());
         end
      end
   end

   // Watchdog: end the run if no word moves on any channel for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("line_substring_match_all_core: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_matches();
      test_query_extremes();
      // Random phases: no idling, idle sender, stalling receiver, both.
      test_random_buffers(0, 0, 130);
      test_random_buffers(45, 0, 130);
      test_random_buffers(0, 45, 130);
      test_random_buffers(14, 14, 130);
      settle();
      if (mismatch_count == 0)
         $display("line_substring_match_all_core: match");
      else
         $display("line_substring_match_all_core: mismatch");
      $finish;
   end

endmodule
